/* sv/sac_pkg.sv */
// Shared types and constants of the servo angle commander.
package sac_pkg;

    localparam int ANG_W = 14;
    localparam int VAL_W = 15;
    localparam int MP_W  = 15;
    localparam int MAC_W = 32;
    localparam int SRV_W = 8;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [SRV_W-1:0] SERVO_MAX = 8'd180;

    localparam logic CMD_ABS = 1'b0;
    localparam logic CMD_REL = 1'b1;

    typedef enum logic [1:0] {
        ST_MOVED  = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOINIT = 2'd2,
        ST_DEGEN  = 2'd3
    } status_t;

    localparam logic [2:0] REG_MIN_ANGLE = 3'd0;
    localparam logic [2:0] REG_MAX_ANGLE = 3'd1;
    localparam logic [2:0] REG_CAL_ARM_A = 3'd2;
    localparam logic [2:0] REG_CAL_ARM_B = 3'd3;
    localparam logic [2:0] REG_CAL_SRV_A = 3'd4;
    localparam logic [2:0] REG_CAL_SRV_B = 3'd5;

    localparam logic signed [ANG_W-1:0] RST_MIN_ANGLE = 14'sd0;
    localparam logic signed [ANG_W-1:0] RST_MAX_ANGLE = 14'sd2880;
    localparam logic signed [ANG_W-1:0] RST_CAL_ARM_A = 14'sd0;
    localparam logic signed [ANG_W-1:0] RST_CAL_ARM_B = 14'sd2880;
    localparam logic signed [ANG_W-1:0] RST_CAL_SRV_A = 14'sd0;
    localparam logic signed [ANG_W-1:0] RST_CAL_SRV_B = 14'sd2880;

    typedef struct packed {
        logic             done;
        logic             clipped;
        logic [SRV_W-1:0] angle;
    } div_res_t;

endpackage

/* sv/sac_mac.sv */
// Bit-serial dual multiply-accumulate: acc = mcand0*mplier0 + mcand1*mplier1.
module sac_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [sac_pkg::ANG_W-1:0]   mcand0,
    input  logic signed [sac_pkg::MP_W-1:0]    mplier0,
    input  logic signed [sac_pkg::MP_W-1:0]    mcand1,
    input  logic signed [sac_pkg::MP_W-1:0]    mplier1,
    output logic signed [sac_pkg::MAC_W-1:0]   acc,
    output logic                               done
);

    localparam int CNT_W = $clog2(sac_pkg::MP_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sac_pkg::MP_W - 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic signed [sac_pkg::MAC_W-1:0]  mc0_reg, mc0_next;
    logic signed [sac_pkg::MAC_W-1:0]  mc1_reg, mc1_next;
    logic [sac_pkg::MP_W-1:0]          mp0_reg, mp0_next;
    logic [sac_pkg::MP_W-1:0]          mp1_reg, mp1_next;
    logic signed [sac_pkg::MAC_W-1:0]  acc_reg, acc_next;
    logic                              last;
    logic signed [sac_pkg::MAC_W-1:0]  term0, term1;

    assign last  = (cnt_reg == CNT_LAST);
    assign term0 = mp0_reg[0] ? (last ? -mc0_reg : mc0_reg) : '0;
    assign term1 = mp1_reg[0] ? (last ? -mc1_reg : mc1_reg) : '0;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mc0_next  = mc0_reg;
        mc1_next  = mc1_reg;
        mp0_next  = mp0_reg;
        mp1_next  = mp1_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mc0_next  = sac_pkg::MAC_W'(mcand0);
            mc1_next  = sac_pkg::MAC_W'(mcand1);
            mp0_next  = mplier0;
            mp1_next  = mplier1;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + term0 + term1;
            mc0_next = mc0_reg <<< 1;
            mc1_next = mc1_reg <<< 1;
            mp0_next = mp0_reg >> 1;
            mp1_next = mp1_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mc0_reg <= mc0_next;
        mc1_reg <= mc1_next;
        mp0_reg <= mp0_next;
        mp1_reg <= mp1_next;
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("mac done while still busy");

    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == '0)
        else $error("mac did not start");

    a_last_gives_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && last && !start) |=> done_reg)
        else $error("mac missed done");

endmodule

/* sv/sac_div.sv */
// Restoring divider, one quotient bit per cycle, with round-half-up and saturation.
module sac_div #(
    parameter int FRAC_BITS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [sac_pkg::MAC_W-1:0]  num,
    input  logic signed [sac_pkg::MP_W-1:0]   dif,
    output sac_pkg::div_res_t                 res
);

    localparam int LW_A = sac_pkg::MAC_W + 2;
    localparam int LW_B = sac_pkg::MP_W + FRAC_BITS + sac_pkg::SRV_W + 2;
    localparam int LW = (LW_A > LW_B) ? LW_A : LW_B;
    localparam int STEPS = sac_pkg::SRV_W + 1;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [LW-1:0]                    rem_reg, rem_next;
    logic [LW-1:0]                    dsh_reg, dsh_next;
    logic [sac_pkg::SRV_W:0]          quo_reg, quo_next;
    logic                             neg_reg, neg_next;

    logic signed [sac_pkg::MAC_W-1:0] num_adj;
    logic [sac_pkg::MP_W-1:0]         dif_abs;
    logic [LW-1:0]                    den_ext;
    logic signed [LW-1:0]             n_val;
    logic                             ge;
    logic                             over;

    assign num_adj = dif[sac_pkg::MP_W-1] ? -num : num;
    assign dif_abs = dif[sac_pkg::MP_W-1] ? sac_pkg::MP_W'(-dif) : sac_pkg::MP_W'(dif);
    assign den_ext = LW'(dif_abs) << FRAC_BITS;
    assign n_val   = (LW'(num_adj) <<< 1) + $signed(den_ext);
    assign ge      = (rem_reg >= dsh_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = n_val;
            dsh_next  = den_ext << (sac_pkg::SRV_W + 1);
            quo_next  = '0;
            neg_next  = n_val[LW-1];
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[sac_pkg::SRV_W-1:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign over = quo_reg[sac_pkg::SRV_W] ||
                  (quo_reg[sac_pkg::SRV_W-1:0] > sac_pkg::SERVO_MAX);

    always_comb begin
        res.done = done_reg;
        if (neg_reg) begin
            res.clipped = 1'b1;
            res.angle   = '0;
        end else if (over) begin
            res.clipped = 1'b1;
            res.angle   = sac_pkg::SERVO_MAX;
        end else begin
            res.clipped = 1'b0;
            res.angle   = quo_reg[sac_pkg::SRV_W-1:0];
        end
    end

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_angle_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> res.angle <= sac_pkg::SERVO_MAX)
        else $error("servo angle above limit");

    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == '0)
        else $error("divider did not start");

endmodule

/* sv/servo_angle_commander.sv */
// Servo angle commander: move checks, arm angle state and serial calibration mapping.
//
// One command is handled at a time. A refused command (no initial angle, out of
// window, degenerate calibration) goes from idle straight to the output state.
// A successful move runs through the bit-serial multiply-accumulate (one multiplier
// bit per cycle over the 15-bit calibration differences), then the restoring
// divider (load plus nine quotient bits), and then the result is captured,
// registered and handed over.
// The output register lets the next command be taken while a result still waits.
// Configuration registers sit at byte addresses 0x00..0x14, decoded on paddr[4:2]; writes to 0x18..0x1F are dropped.
module servo_angle_commander #(
    parameter int FRAC_BITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic signed [sac_pkg::VAL_W-1:0]    s_angle_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic                                m_servo_write,
    output logic [sac_pkg::SRV_W-1:0]           m_servo_angle,
    output logic                                m_servo_clipped,
    output logic signed [sac_pkg::ANG_W-1:0]    m_present_angle,
    output logic                                m_angle_known,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sac_pkg::ADDR_W-1:0]          paddr,
    input  logic [sac_pkg::DATA_W-1:0]          pwdata,
    output logic [sac_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int TW = sac_pkg::ANG_W + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic signed [sac_pkg::ANG_W-1:0] min_angle_reg, max_angle_reg;
    logic signed [sac_pkg::ANG_W-1:0] cal_arm_a_reg, cal_arm_b_reg;
    logic signed [sac_pkg::ANG_W-1:0] cal_srv_a_reg, cal_srv_b_reg;

    logic signed [sac_pkg::ANG_W-1:0] arm_angle_reg, arm_angle_next;
    logic                             angle_valid_reg, angle_valid_next;

    sac_pkg::status_t                 hold_status_reg, hold_status_next;
    logic                             hold_write_reg, hold_write_next;
    logic [sac_pkg::SRV_W-1:0]        hold_angle_reg, hold_angle_next;
    logic                             hold_clip_reg, hold_clip_next;

    logic                             m_valid_reg, m_valid_next;
    sac_pkg::status_t                 m_status_reg;
    logic                             m_write_reg;
    logic [sac_pkg::SRV_W-1:0]        m_angle_reg;
    logic                             m_clip_reg;
    logic signed [sac_pkg::ANG_W-1:0] m_present_reg;
    logic                             m_known_reg;

    logic                             in_acc;
    logic                             cfg_wr;
    logic                             out_load;
    logic signed [TW-1:0]             target;
    logic                             in_window;
    sac_pkg::status_t                 chk_status;
    logic                             mac_start;
    logic                             div_start;
    logic signed [sac_pkg::MP_W-1:0]  dif_ba;
    logic signed [sac_pkg::MP_W-1:0]  dif_bx;
    logic signed [sac_pkg::MP_W-1:0]  dif_s;
    logic signed [sac_pkg::MAC_W-1:0] mac_acc;
    logic                             mac_done;
    sac_pkg::div_res_t                div_res;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    assign target = (s_cmd == sac_pkg::CMD_REL) ?
                    (TW'(arm_angle_reg) + TW'(s_angle_value)) : TW'(s_angle_value);
    assign in_window = (target >= TW'(min_angle_reg)) && (target <= TW'(max_angle_reg));

    always_comb begin
        if (s_cmd == sac_pkg::CMD_REL && !angle_valid_reg) begin
            chk_status = sac_pkg::ST_NOINIT;
        end else if (!in_window) begin
            chk_status = sac_pkg::ST_RANGE;
        end else if (cal_arm_a_reg == cal_arm_b_reg) begin
            chk_status = sac_pkg::ST_DEGEN;
        end else begin
            chk_status = sac_pkg::ST_MOVED;
        end
    end

    assign dif_ba = sac_pkg::MP_W'(cal_arm_b_reg) - sac_pkg::MP_W'(cal_arm_a_reg);
    assign dif_bx = sac_pkg::MP_W'(cal_arm_b_reg) - sac_pkg::MP_W'(target);
    assign dif_s  = sac_pkg::MP_W'(cal_srv_a_reg) - sac_pkg::MP_W'(cal_srv_b_reg);

    sac_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .mcand0  (cal_srv_b_reg),
        .mplier0 (dif_ba),
        .mcand1  (dif_bx),
        .mplier1 (dif_s),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    sac_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mac_acc),
        .dif     (dif_ba),
        .res     (div_res)
    );

    always_comb begin
        state_next       = state_reg;
        arm_angle_next   = arm_angle_reg;
        angle_valid_next = angle_valid_reg;
        hold_status_next = hold_status_reg;
        hold_write_next  = hold_write_reg;
        hold_angle_next  = hold_angle_reg;
        hold_clip_next   = hold_clip_reg;
        mac_start        = 1'b0;
        div_start        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    hold_status_next = chk_status;
                    hold_write_next  = 1'b0;
                    hold_angle_next  = '0;
                    hold_clip_next   = 1'b0;
                    if (chk_status == sac_pkg::ST_MOVED) begin
                        arm_angle_next   = target[sac_pkg::ANG_W-1:0];
                        angle_valid_next = 1'b1;
                        mac_start        = 1'b1;
                        state_next       = S_MUL;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL: begin
                if (mac_done) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    hold_write_next = 1'b1;
                    hold_angle_next = div_res.angle;
                    hold_clip_next  = div_res.clipped;
                    state_next      = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            arm_angle_reg   <= '0;
            angle_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            min_angle_reg   <= sac_pkg::RST_MIN_ANGLE;
            max_angle_reg   <= sac_pkg::RST_MAX_ANGLE;
            cal_arm_a_reg   <= sac_pkg::RST_CAL_ARM_A;
            cal_arm_b_reg   <= sac_pkg::RST_CAL_ARM_B;
            cal_srv_a_reg   <= sac_pkg::RST_CAL_SRV_A;
            cal_srv_b_reg   <= sac_pkg::RST_CAL_SRV_B;
        end else begin
            state_reg       <= state_next;
            arm_angle_reg   <= arm_angle_next;
            angle_valid_reg <= angle_valid_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr) begin
                case (paddr[4:2])
                    sac_pkg::REG_MIN_ANGLE: min_angle_reg <= pwdata[sac_pkg::ANG_W-1:0];
                    sac_pkg::REG_MAX_ANGLE: max_angle_reg <= pwdata[sac_pkg::ANG_W-1:0];
                    sac_pkg::REG_CAL_ARM_A: cal_arm_a_reg <= pwdata[sac_pkg::ANG_W-1:0];
                    sac_pkg::REG_CAL_ARM_B: cal_arm_b_reg <= pwdata[sac_pkg::ANG_W-1:0];
                    sac_pkg::REG_CAL_SRV_A: cal_srv_a_reg <= pwdata[sac_pkg::ANG_W-1:0];
                    sac_pkg::REG_CAL_SRV_B: cal_srv_b_reg <= pwdata[sac_pkg::ANG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        hold_status_reg <= hold_status_next;
        hold_write_reg  <= hold_write_next;
        hold_angle_reg  <= hold_angle_next;
        hold_clip_reg   <= hold_clip_next;
        if (out_load) begin
            m_status_reg  <= hold_status_reg;
            m_write_reg   <= hold_write_reg;
            m_angle_reg   <= hold_angle_reg;
            m_clip_reg    <= hold_clip_reg;
            m_present_reg <= arm_angle_reg;
            m_known_reg   <= angle_valid_reg;
        end
    end

    always_comb begin
        case (paddr[4:2])
            sac_pkg::REG_MIN_ANGLE: prdata = sac_pkg::DATA_W'(min_angle_reg);
            sac_pkg::REG_MAX_ANGLE: prdata = sac_pkg::DATA_W'(max_angle_reg);
            sac_pkg::REG_CAL_ARM_A: prdata = sac_pkg::DATA_W'(cal_arm_a_reg);
            sac_pkg::REG_CAL_ARM_B: prdata = sac_pkg::DATA_W'(cal_arm_b_reg);
            sac_pkg::REG_CAL_SRV_A: prdata = sac_pkg::DATA_W'(cal_srv_a_reg);
            sac_pkg::REG_CAL_SRV_B: prdata = sac_pkg::DATA_W'(cal_srv_b_reg);
            default:                prdata = '0;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_servo_write   = m_write_reg;
    assign m_servo_angle   = m_angle_reg;
    assign m_servo_clipped = m_clip_reg;
    assign m_present_angle = m_present_reg;
    assign m_angle_known   = m_known_reg;

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");

    a_write_iff_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_servo_write == (m_status == sac_pkg::ST_MOVED)))
        else $error("servo write does not match status");

    a_refused_is_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_servo_write) |-> (m_servo_angle == '0 && !m_servo_clipped))
        else $error("refused request carries a servo angle");

    a_moved_sets_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == sac_pkg::ST_MOVED) |-> m_angle_known)
        else $error("move without angle known");

    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside its phase");

endmodule

/* tb/servo_angle_commander_tb.sv */
`timescale 1ns / 1ps
// Testbench for the servo angle commander: table-driven and random move requests against a predictor.
module servo_angle_commander_tb;

    localparam int FRAC_BITS       = 4;
    localparam int RUN_LIMIT       = 400000;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 10;
    localparam int MOVES_PER_PHASE = 85;
    localparam int ANGLE_LIM       = 5760;
    localparam int VALUE_LIM       = 11520;
    localparam int TAIL_CYCLES     = 40;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        sac_pkg::status_t                 status;
        logic                             wr;
        logic [sac_pkg::SRV_W-1:0]        srv;
        logic                             clip;
        logic signed [sac_pkg::ANG_W-1:0] pos;
        logic                             known;
    } move_result_t;

    typedef enum logic {ROW_MOVE, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic                             cmd;
        logic [2:0]                       idx;
        logic signed [sac_pkg::VAL_W-1:0] value;
        logic                             typed;
        move_result_t                     result;
    } stim_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_cmd;
    logic signed [sac_pkg::VAL_W-1:0] s_angle_value;
    logic                             m_valid;
    logic                             m_ready;
    logic [1:0]                       m_status;
    logic                             m_servo_write;
    logic [sac_pkg::SRV_W-1:0]        m_servo_angle;
    logic                             m_servo_clipped;
    logic signed [sac_pkg::ANG_W-1:0] m_present_angle;
    logic                             m_angle_known;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [sac_pkg::ADDR_W-1:0]       paddr;
    logic [sac_pkg::DATA_W-1:0]       pwdata;
    logic [sac_pkg::DATA_W-1:0]       prdata;
    logic                             pready;

    logic signed [sac_pkg::ANG_W-1:0] win_lo, win_hi;
    logic signed [sac_pkg::ANG_W-1:0] cal_arm_a, cal_arm_b, cal_srv_a, cal_srv_b;
    logic signed [sac_pkg::ANG_W-1:0] arm_pos;
    logic                             arm_known;

    move_result_t pending_moves[$];
    stim_row_t    stim_rows[$];
    int           fail_count = 0;
    int           idle_pct = 0;
    logic         hold_req = 1'b0;
    int           cycle_cnt;

    servo_angle_commander #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_angle_value(s_angle_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_servo_write(m_servo_write),
        .m_servo_angle(m_servo_angle),
        .m_servo_clipped(m_servo_clipped),
        .m_present_angle(m_present_angle),
        .m_angle_known(m_angle_known),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic logic [sac_pkg::SRV_W-1:0] servo_degrees(input int x,
                                                                output logic clip);
        longint a, b, sa, sb, num, den, q;
        a = longint'(cal_arm_a);
        b = longint'(cal_arm_b);
        sa = longint'(cal_srv_a);
        sb = longint'(cal_srv_b);
        num = sb * (b - a) + (b - longint'(x)) * (sa - sb);
        den = (b - a) * (longint'(1) << FRAC_BITS);
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        num = 2 * num + den;
        den = 2 * den;
        q = num / den;
        if (num % den != 0 && num < 0) begin
            q = q - 1;
        end
        clip = (q < 0) || (q > 180);
        if (q < 0) begin
            return '0;
        end
        if (q > 180) begin
            return sac_pkg::SERVO_MAX;
        end
        return q[sac_pkg::SRV_W-1:0];
    endfunction

    function automatic move_result_t predict_move(input logic cmd,
                                                  input logic signed [sac_pkg::VAL_W-1:0] val);
        move_result_t r;
        int           target;
        logic         clip;
        r = '0;
        r.status = sac_pkg::ST_MOVED;
        target = int'(val);
        if (cmd == sac_pkg::CMD_REL) begin
            if (!arm_known) begin
                r.status = sac_pkg::ST_NOINIT;
            end else begin
                target = int'(arm_pos) + int'(val);
            end
        end
        if (r.status == sac_pkg::ST_MOVED &&
            (target < int'(win_lo) || target > int'(win_hi))) begin
            r.status = sac_pkg::ST_RANGE;
        end
        if (r.status == sac_pkg::ST_MOVED && cal_arm_a == cal_arm_b) begin
            r.status = sac_pkg::ST_DEGEN;
        end
        if (r.status == sac_pkg::ST_MOVED) begin
            arm_pos = target[sac_pkg::ANG_W-1:0];
            arm_known = 1'b1;
            r.wr = 1'b1;
            r.srv = servo_degrees(target, clip);
            r.clip = clip;
        end
        r.pos = arm_pos;
        r.known = arm_known;
        return r;
    endfunction

    task automatic add_move(input logic cmd, input int val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_MOVE;
        r.cmd = cmd;
        r.value = sac_pkg::VAL_W'(val);
        stim_rows.push_back(r);
    endtask

    task automatic add_move_exp(input logic cmd, input int val, input sac_pkg::status_t st,
                                input int srv, input logic clip, input int pos,
                                input logic known);
        stim_row_t r;
        r = '0;
        r.kind = ROW_MOVE;
        r.cmd = cmd;
        r.value = sac_pkg::VAL_W'(val);
        r.typed = 1'b1;
        r.result.status = st;
        r.result.wr = (st == sac_pkg::ST_MOVED);
        r.result.srv = sac_pkg::SRV_W'(srv);
        r.result.clip = clip;
        r.result.pos = sac_pkg::ANG_W'(pos);
        r.result.known = known;
        stim_rows.push_back(r);
    endtask

    task automatic add_reg(input logic [2:0] idx, input int val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.idx = idx;
        r.value = sac_pkg::VAL_W'(val);
        stim_rows.push_back(r);
    endtask

    task automatic send_move(input logic cmd, input logic signed [sac_pkg::VAL_W-1:0] val,
                             input logic typed, input move_result_t typed_result);
        move_result_t predicted;
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_angle_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_move(cmd, val);
        pending_moves.push_back(typed ? typed_result : predicted);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_moves.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx,
                             input logic signed [sac_pkg::ANG_W-1:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{(sac_pkg::DATA_W-sac_pkg::ANG_W){v[sac_pkg::ANG_W-1]}}, v};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            sac_pkg::REG_MIN_ANGLE: win_lo = v;
            sac_pkg::REG_MAX_ANGLE: win_hi = v;
            sac_pkg::REG_CAL_ARM_A: cal_arm_a = v;
            sac_pkg::REG_CAL_ARM_B: cal_arm_b = v;
            sac_pkg::REG_CAL_SRV_A: cal_srv_a = v;
            sac_pkg::REG_CAL_SRV_B: cal_srv_b = v;
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_phase_cfg(input int phase);
        int lo, hi, a, b, sa, sb, tmp, shape;
        shape = (phase == PHASES - 1) ? 7 : int'($urandom_range(7, 0));
        lo = rand_span(-ANGLE_LIM, 0);
        hi = rand_span(0, ANGLE_LIM);
        a = rand_span(-ANGLE_LIM, 2000);
        b = a + rand_span(500, 3760);
        sa = rand_span(-160, 1440);
        sb = rand_span(1440, 3040);
        if ($urandom_range(1, 0)) begin
            tmp = a;
            a = b;
            b = tmp;
        end
        case (shape)
            0: begin
                lo = -ANGLE_LIM;
                hi = ANGLE_LIM;
                a = $urandom_range(1, 0) ? ANGLE_LIM : -ANGLE_LIM;
                b = $urandom_range(1, 0) ? ANGLE_LIM : -ANGLE_LIM;
                sa = $urandom_range(1, 0) ? ANGLE_LIM : -ANGLE_LIM;
                sb = $urandom_range(1, 0) ? ANGLE_LIM : -ANGLE_LIM;
            end
            1: b = a;
            2: begin
                lo = rand_span(1, ANGLE_LIM);
                hi = rand_span(-ANGLE_LIM, 0);
            end
            default: ;
        endcase
        drain();
        write_reg(sac_pkg::REG_MIN_ANGLE, sac_pkg::ANG_W'(lo));
        write_reg(sac_pkg::REG_MAX_ANGLE, sac_pkg::ANG_W'(hi));
        write_reg(sac_pkg::REG_CAL_ARM_A, sac_pkg::ANG_W'(a));
        write_reg(sac_pkg::REG_CAL_ARM_B, sac_pkg::ANG_W'(b));
        write_reg(sac_pkg::REG_CAL_SRV_A, sac_pkg::ANG_W'(sa));
        write_reg(sac_pkg::REG_CAL_SRV_B, sac_pkg::ANG_W'(sb));
        if (shape == 0) begin
            write_reg(REG_SPARE_6, sac_pkg::ANG_W'(rand_span(-ANGLE_LIM, ANGLE_LIM)));
            write_reg(REG_SPARE_7, sac_pkg::ANG_W'(rand_span(-ANGLE_LIM, ANGLE_LIM)));
        end
    endtask

    // hold off the result side for a long stretch on request, else stall in short bursts while idle_pct is set
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 1)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        move_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_moves.size() == 0) begin
                fail_count++;
                $display("%0t: expected no result, actual status=%0d write=%0d servo=%0d",
                         $time, m_status, m_servo_write, m_servo_angle);
            end else begin
                want = pending_moves.pop_front();
                if (m_status !== want.status || m_servo_write !== want.wr ||
                    m_servo_angle !== want.srv || m_servo_clipped !== want.clip ||
                    m_present_angle !== want.pos || m_angle_known !== want.known) begin
                    fail_count++;
                    $display(
                        "%0t: expected status=%0d write=%0d servo=%0d clip=%0d angle=%0d known=%0d",
                        $time, want.status, want.wr, want.srv, want.clip,
                        $signed(want.pos), want.known);
                    $display(
                        "%0t: actual   status=%0d write=%0d servo=%0d clip=%0d angle=%0d known=%0d",
                        $time, m_status, m_servo_write, m_servo_angle, m_servo_clipped,
                        m_present_angle, m_angle_known);
                end
            end
        end
    end

    initial begin
        for (cycle_cnt = 0; cycle_cnt < RUN_LIMIT; cycle_cnt++) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int        pick, val;
        logic      cmd;
        stim_row_t row;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = sac_pkg::CMD_ABS;
        s_angle_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        win_lo = sac_pkg::RST_MIN_ANGLE;
        win_hi = sac_pkg::RST_MAX_ANGLE;
        cal_arm_a = sac_pkg::RST_CAL_ARM_A;
        cal_arm_b = sac_pkg::RST_CAL_ARM_B;
        cal_srv_a = sac_pkg::RST_CAL_SRV_A;
        cal_srv_b = sac_pkg::RST_CAL_SRV_B;
        arm_pos = '0;
        arm_known = 1'b0;

        add_move_exp(sac_pkg::CMD_REL, 5, sac_pkg::ST_NOINIT, 0, 1'b0, 0, 1'b0);
        add_move_exp(sac_pkg::CMD_REL, -VALUE_LIM, sac_pkg::ST_NOINIT, 0, 1'b0, 0, 1'b0);
        add_move_exp(sac_pkg::CMD_ABS, -1, sac_pkg::ST_RANGE, 0, 1'b0, 0, 1'b0);
        add_move_exp(sac_pkg::CMD_ABS, 2881, sac_pkg::ST_RANGE, 0, 1'b0, 0, 1'b0);
        add_move_exp(sac_pkg::CMD_ABS, 0, sac_pkg::ST_MOVED, 0, 1'b0, 0, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, 2880, sac_pkg::ST_MOVED, 180, 1'b0, 2880, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, 8, sac_pkg::ST_MOVED, 1, 1'b0, 8, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, 7, sac_pkg::ST_MOVED, 0, 1'b0, 7, 1'b1);
        add_move_exp(sac_pkg::CMD_REL, 1, sac_pkg::ST_MOVED, 1, 1'b0, 8, 1'b1);
        add_move_exp(sac_pkg::CMD_REL, VALUE_LIM, sac_pkg::ST_RANGE, 0, 1'b0, 8, 1'b1);
        add_move_exp(sac_pkg::CMD_REL, -VALUE_LIM, sac_pkg::ST_RANGE, 0, 1'b0, 8, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, VALUE_LIM, sac_pkg::ST_RANGE, 0, 1'b0, 8, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, -VALUE_LIM, sac_pkg::ST_RANGE, 0, 1'b0, 8, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, 1448, sac_pkg::ST_MOVED, 91, 1'b0, 1448, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, 1447, sac_pkg::ST_MOVED, 90, 1'b0, 1447, 1'b1);
        add_reg(sac_pkg::REG_CAL_ARM_B, 0);
        add_move_exp(sac_pkg::CMD_ABS, 100, sac_pkg::ST_DEGEN, 0, 1'b0, 1447, 1'b1);
        add_move_exp(sac_pkg::CMD_REL, 0, sac_pkg::ST_DEGEN, 0, 1'b0, 1447, 1'b1);
        add_reg(sac_pkg::REG_MIN_ANGLE, -ANGLE_LIM);
        add_reg(sac_pkg::REG_MAX_ANGLE, ANGLE_LIM);
        add_reg(sac_pkg::REG_CAL_ARM_B, -2880);
        add_move_exp(sac_pkg::CMD_ABS, ANGLE_LIM, sac_pkg::ST_MOVED, 0, 1'b1,
                     ANGLE_LIM, 1'b1);
        add_move_exp(sac_pkg::CMD_ABS, -ANGLE_LIM, sac_pkg::ST_MOVED, 180, 1'b1,
                     -ANGLE_LIM, 1'b1);
        add_move(sac_pkg::CMD_ABS, -1000);
        add_move(sac_pkg::CMD_REL, VALUE_LIM);
        add_reg(sac_pkg::REG_MIN_ANGLE, ANGLE_LIM);
        add_reg(sac_pkg::REG_MAX_ANGLE, -ANGLE_LIM);
        add_move_exp(sac_pkg::CMD_ABS, 0, sac_pkg::ST_RANGE, 0, 1'b0, -1000, 1'b1);
        add_move_exp(sac_pkg::CMD_REL, 0, sac_pkg::ST_RANGE, 0, 1'b0, -1000, 1'b1);
        add_reg(REG_SPARE_6, 1);
        add_reg(REG_SPARE_7, -1);
        add_move_exp(sac_pkg::CMD_ABS, ANGLE_LIM, sac_pkg::ST_RANGE, 0, 1'b0, -1000, 1'b1);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_pct = 25;
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_REG) begin
                drain();
                write_reg(row.idx, row.value[sac_pkg::ANG_W-1:0]);
            end else begin
                send_move(row.cmd, row.value, row.typed, row.result);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            load_phase_cfg(phase);
            case ($urandom_range(2, 0))
                0: idle_pct = 0;
                1: idle_pct = 20;
                default: idle_pct = 50;
            endcase
            if (phase == PHASES - 1) begin
                idle_pct = 0;
            end
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < MOVES_PER_PHASE; n++) begin
                pick = int'($urandom_range(9, 0));
                cmd = sac_pkg::CMD_ABS;
                if (pick <= 3) begin
                    val = (win_lo <= win_hi) ? rand_span(int'(win_lo), int'(win_hi))
                                             : rand_span(-VALUE_LIM, VALUE_LIM);
                end else if (pick <= 6) begin
                    cmd = sac_pkg::CMD_REL;
                    val = rand_span(-48, 48);
                end else if (pick == 7) begin
                    cmd = sac_pkg::CMD_REL;
                    val = rand_span(-VALUE_LIM, VALUE_LIM);
                end else if (pick == 8) begin
                    val = rand_span(-VALUE_LIM, VALUE_LIM);
                end else begin
                    case ($urandom_range(5, 0))
                        0: val = int'(win_lo) - 1;
                        1: val = int'(win_lo);
                        2: val = int'(win_hi);
                        3: val = int'(win_hi) + 1;
                        4: val = VALUE_LIM;
                        default: val = -VALUE_LIM;
                    endcase
                end
                send_move(cmd, val[sac_pkg::VAL_W-1:0], 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_moves.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/sac_pkg.sv
sv/sac_mac.sv
sv/sac_div.sv
sv/servo_angle_commander.sv
tb/servo_angle_commander_tb.sv
